FILE: rtl/krst_pkg.sv
// keyed running statistics table: shared types and constants
// no dependencies
`default_nettype none
package krst_pkg;
   localparam int ENTRIES_DEFAULT  = 16;
   localparam int KEY_BITS_DEFAULT = 32;

   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_UPDATED = 3'd0,
      ST_CREATED = 3'd1,
      ST_STATS   = 3'd2,
      ST_MISSING = 3'd3,
      ST_REMOVED = 3'd4,
      ST_FULL    = 3'd5
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/keyed_running_statistics_table_top.sv
// keyed running statistics table, top level
// uses krst_pkg and krst_divider
`default_nettype none
// Keeps up to ENTRIES records, each keyed by the low KEY_BITS bits of req_key,
// holding a saturating sample count, a 64-bit sum, a minimum and a maximum.
// One command is worked at a time and req_stall stays high until it is done.
// Lookup scans the record memory one slot per cycle (the memory read is
// registered), then the record is read (S_RD, S_RDW) and updated or written
// back in S_WORK. The result fields are registered in S_WORK (the mean of a
// query in S_DIV), and rsp_valid is raised from S_OUT before S_IDLE returns.
// A query further runs a 64-bit bit-serial divider for the mean in S_DIV.
// A result still waiting in the rsp_ registers holds the next command before
// its update step until it is transferred. Valid bits are flip-flops cleared
// by reset; record fields are held in one synchronous memory. Command 3 is
// taken and gives no result.
module keyed_running_statistics_table_top #(
   parameter int ENTRIES  = krst_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = krst_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_key,
   input  wire logic signed [31:0] req_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_sample_count,
   output logic signed [31:0] rsp_min_value,
   output logic signed [31:0] rsp_max_value,
   output logic signed [31:0] rsp_mean_value
);
   import krst_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int RW = KW + 32 + 64 + 32 + 32;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_RD    = 7'b0000100,
      S_RDW   = 7'b0001000,
      S_WORK  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   // record memory: {key, count, sum, min, max}
   logic [RW-1:0] rec_mem [ENTRIES];
   logic [RW-1:0] rec_rd_ff;
   logic          rec_we;
   logic [IW-1:0] rec_waddr, rec_raddr;
   logic [RW-1:0] rec_wdata;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   state_type state_ff, state_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [KW-1:0] key_ff, key_in;
   logic [31:0]   smp_ff, smp_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          neg_ff, neg_in;

   logic          out_v_ff, out_v_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   cnt_o_ff, cnt_o_in, min_o_ff, min_o_in, max_o_ff, max_o_in;
   logic [31:0]   mean_o_ff, mean_o_in;

   logic          div_start, div_done;
   logic [63:0]   div_quo, div_dvd;

   // fields of the record just read
   logic [KW-1:0] r_key;
   logic [31:0]   r_cnt, r_min, r_max;
   logic [63:0]   r_sum;
   logic [IW-1:0] prev_idx;
   logic          prev_valid;
   logic [IW-1:0] free_idx;
   logic          free_any;

   assign {r_key, r_cnt, r_sum, r_min, r_max} = rec_rd_ff;

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   // lowest free slot from the valid bits
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            free_any = 1'b1;
         end
      end
   end

   // slot whose data arrives this cycle during the scan
   assign prev_idx   = IW'(scan_ff - CW'(1));
   assign prev_valid = valid_ff[prev_idx];

   krst_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (r_cnt),
      .done     (div_done),
      .quotient (div_quo)
   );
   assign div_dvd = r_sum[63] ? (~r_sum + 64'd1) : r_sum;

   always_comb begin
      logic [31:0] n_cnt, n_min, n_max;
      logic [63:0] n_sum, sx;
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      smp_in    = smp_ff;
      scan_in   = scan_ff;
      hit_in    = hit_ff;
      idx_in    = idx_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff;
      out_v_in  = out_v_ff;
      st_in     = st_ff;
      cnt_o_in  = cnt_o_ff;
      min_o_in  = min_o_ff;
      max_o_in  = max_o_ff;
      mean_o_in = mean_o_ff;
      rec_we    = 1'b0;
      rec_waddr = idx_ff;
      rec_wdata = '0;
      rec_raddr = scan_ff[IW-1:0];
      div_start = 1'b0;
      sx        = {{32{smp_ff[31]}}, smp_ff};
      n_cnt     = r_cnt;
      n_sum     = r_sum;
      n_min     = r_min;
      n_max     = r_max;

      // output register drains independently
      if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               key_in  = req_key[KW-1:0];
               smp_in  = req_sample;
               scan_in = '0;
               hit_in  = 1'b0;
               if (req_command != CMD_NONE) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read address scan_ff issued, data of scan_ff-1 visible
            rec_raddr = scan_ff[IW-1:0];
            if (scan_ff != '0 && !hit_ff && prev_valid && r_key == key_ff) begin
               hit_in = 1'b1;
               idx_in = prev_idx;
            end
            if (scan_ff == CW'(ENTRIES)) begin
               state_in = S_RD;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         S_RD: begin
            rec_raddr = idx_ff;
            state_in  = S_RDW;
         end
         S_RDW: begin
            // hold here while the previous result still waits in the rsp_ registers
            rec_raddr = idx_ff;
            if (!out_v_ff) begin
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            cnt_o_in  = '0;
            min_o_in  = '0;
            max_o_in  = '0;
            mean_o_in = '0;
            state_in  = S_OUT;
            case (cmd_ff)
               CMD_READ: begin
                  if (hit_ff) begin
                     if (r_cnt != 32'hFFFF_FFFF) begin
                        n_cnt = r_cnt + 32'd1;
                        n_sum = r_sum + sx;
                     end
                     if ($signed(smp_ff) < $signed(r_min)) n_min = smp_ff;
                     if ($signed(r_max) < $signed(smp_ff)) n_max = smp_ff;
                     rec_we    = 1'b1;
                     rec_waddr = idx_ff;
                     rec_wdata = {r_key, n_cnt, n_sum, n_min, n_max};
                     st_in     = ST_UPDATED;
                  end else if (free_any) begin
                     rec_we    = 1'b1;
                     rec_waddr = free_idx;
                     rec_wdata = {key_ff, 32'd1, sx, smp_ff, smp_ff};
                     valid_in[free_idx] = 1'b1;
                     st_in     = ST_CREATED;
                  end else begin
                     st_in     = ST_FULL;
                  end
               end
               CMD_QUERY: begin
                  if (hit_ff) begin
                     st_in     = ST_STATS;
                     cnt_o_in  = r_cnt;
                     min_o_in  = r_min;
                     max_o_in  = r_max;
                     neg_in    = r_sum[63];
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end else begin
                     st_in = ST_MISSING;
                  end
               end
               CMD_REMOVE: begin
                  if (hit_ff) begin
                     valid_in[idx_ff] = 1'b0;
                     st_in = ST_REMOVED;
                  end else begin
                     st_in = ST_MISSING;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            rec_raddr = idx_ff;
            if (div_done) begin
               mean_o_in = neg_ff ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      smp_ff    <= smp_in;
      scan_ff   <= scan_in;
      hit_ff    <= hit_in;
      idx_ff    <= idx_in;
      neg_ff    <= neg_in;
      st_ff     <= st_in;
      cnt_o_ff  <= cnt_o_in;
      min_o_ff  <= min_o_in;
      max_o_ff  <= max_o_in;
      mean_o_ff <= mean_o_in;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         out_v_ff <= out_v_in;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = out_v_ff;
   assign rsp_status       = st_ff;
   assign rsp_sample_count = cnt_o_ff;
   assign rsp_min_value    = min_o_ff;
   assign rsp_max_value    = max_o_ff;
   assign rsp_mean_value   = mean_o_ff;
endmodule
`default_nettype wire

FILE: rtl/krst_divider.sv
// keyed running statistics table: restoring 64 by 32 bit unsigned divider,
// one quotient bit per cycle; uses krst_pkg
`default_nettype none
module krst_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   import krst_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: verif/tb.sv
// testbench for keyed_running_statistics_table_top: directed and random commands
// uses krst_pkg and the block's RTL; predicts each result with its own table copy
`timescale 1ns / 1ps
module tb;
   import krst_pkg::*;

   localparam int NSLOT = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = CMD_READ;
   logic [31:0] req_key = '0;
   logic signed [31:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [31:0] rsp_sample_count;
   logic signed [31:0] rsp_min_value, rsp_max_value, rsp_mean_value;

   keyed_running_statistics_table_top dut (.*);

   typedef struct packed {
      logic [2:0] status;
      logic [31:0] cnt;
      logic [31:0] mn;
      logic [31:0] mx;
      logic [31:0] mean;
   } answer_type;

   // predictor copy of the table
   logic        rec_used [NSLOT];
   logic [31:0] rec_key [NSLOT];
   logic [31:0] rec_cnt [NSLOT];
   logic [63:0] rec_sum [NSLOT];
   logic signed [31:0] rec_min [NSLOT];
   logic signed [31:0] rec_max [NSLOT];

   answer_type pending_answers[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   logic [31:0] key_pool [8];

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [31:0] mean_of(input logic [63:0] sum, input logic [31:0] cnt);
      logic [63:0] mag;
      logic [63:0] q;
      mag = sum[63] ? -sum : sum;
      q = mag / {32'd0, cnt};
      if (sum[63]) q = -q;
      return q[31:0];
   endfunction

   // applies one command to the predicted table, returns 0 when no result follows
   function automatic bit table_apply(input logic [1:0] cmd, input logic [31:0] k,
                                      input logic signed [31:0] s, output answer_type a);
      int hit;
      int fr;
      hit = -1;
      fr = -1;
      a = '0;
      if (cmd == CMD_NONE) return 0;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (rec_used[i] && rec_key[i] == k) hit = i;
         if (!rec_used[i]) fr = i;
      end
      if (cmd == CMD_READ) begin
         if (hit < 0) begin
            if (fr < 0) a.status = ST_FULL;
            else begin
               rec_used[fr] = 1'b1;
               rec_key[fr] = k;
               rec_cnt[fr] = 32'd1;
               rec_sum[fr] = {{32{s[31]}}, s};
               rec_min[fr] = s;
               rec_max[fr] = s;
               a.status = ST_CREATED;
            end
         end else begin
            if (rec_cnt[hit] != 32'hFFFF_FFFF) begin
               rec_cnt[hit]++;
               rec_sum[hit] += {{32{s[31]}}, s};
            end
            if (s < rec_min[hit]) rec_min[hit] = s;
            if (s > rec_max[hit]) rec_max[hit] = s;
            a.status = ST_UPDATED;
         end
      end else if (hit < 0) a.status = ST_MISSING;
      else if (cmd == CMD_QUERY) begin
         a.status = ST_STATS;
         a.cnt = rec_cnt[hit];
         a.mn = rec_min[hit];
         a.mx = rec_max[hit];
         a.mean = mean_of(rec_sum[hit], rec_cnt[hit]);
      end else begin
         rec_used[hit] = 1'b0;
         a.status = ST_REMOVED;
      end
      return 1;
   endfunction

   // drives one command and waits for its transfer; valid stays up for the next one
   task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] k, input logic [31:0] s);
      answer_type a;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= k;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (table_apply(cmd, k, s, a)) pending_answers.push_back(a);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_answers.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= 200000) begin
         $display("TEST FAILED");
         $finish;
      end
      repeat (120) @(negedge clock);
   endtask

   // receiver stall and long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report("unexpected status", rsp_status, '0);
         end else begin
            w = pending_answers.pop_front();
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
            if (rsp_sample_count !== w.cnt) report("count", rsp_sample_count, w.cnt);
            if (rsp_min_value !== w.mn) report("min", rsp_min_value, w.mn);
            if (rsp_max_value !== w.mx) report("max", rsp_max_value, w.mx);
            if (rsp_mean_value !== w.mean) report("mean", rsp_mean_value, w.mean);
         end
      end
   end

   task automatic test_directed();
      // create, update, query at extremes of sample and key
      send_cmd(CMD_QUERY, 32'h0, 32'h0);
      send_cmd(CMD_READ, 32'h0, 32'h8000_0000);
      send_cmd(CMD_READ, 32'h0, 32'h7FFF_FFFF);
      send_cmd(CMD_READ, 32'h0, 32'hFFFF_FFFF);
      send_cmd(CMD_QUERY, 32'h0, 32'h0);
      send_cmd(CMD_READ, 32'hFFFF_FFFF, 32'h8000_0000);
      send_cmd(CMD_READ, 32'hFFFF_FFFF, 32'h8000_0001);
      send_cmd(CMD_QUERY, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      send_cmd(CMD_NONE, 32'h0, 32'h1);
      send_cmd(CMD_REMOVE, 32'h0, 32'h0);
      send_cmd(CMD_REMOVE, 32'h0, 32'h0);
      send_cmd(CMD_QUERY, 32'h0, 32'h0);
      // fill the table then overflow it
      for (int i = 0; i < NSLOT + 1; i++) send_cmd(CMD_READ, 32'h100 + i, -i);
      send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
      drain();
   endtask

   // mostly reads on a small key pool, so records grow and queries hit
   task automatic test_random(input int n);
      logic [1:0] cmd;
      logic [31:0] k;
      logic [31:0] s;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         cmd = r < 60 ? CMD_READ : r < 85 ? CMD_QUERY : r < 97 ? CMD_REMOVE : CMD_NONE;
         k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(7)];
         s = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(2000)) - 1000;
         send_cmd(cmd, k, s);
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      for (int i = 0; i < 40; i++) send_cmd(i % 3 == 0 ? CMD_QUERY : CMD_READ,
                                           key_pool[i % 8], $urandom);
      drain();
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         rec_used[i] = 1'b0;
         rec_key[i] = '0;
         rec_cnt[i] = '0;
         rec_sum[i] = '0;
         rec_min[i] = '0;
         rec_max[i] = '0;
      end
      for (int i = 0; i < 8; i++) key_pool[i] = (i < 4) ? i : $urandom;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400);
      drain();
      send_idle_pct = 61;
      test_random(400);
      drain();
      send_idle_pct = 0;
      stall_pct = 61;
      test_random(400);
      drain();
      send_idle_pct = 16;
      stall_pct = 16;
      test_random(400);
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
      test_backpressure();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
